FILE: hdl/assert_macros.svh
// Assertion helpers used by the RTL file touch_gesture_to_pointer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/tgp_pkg.sv
package tgp_pkg;

    localparam int ACCEL_W = 16;
    localparam int COUNT_W = 3;
    localparam int POS_W   = 9;
    localparam int TOL_W   = 15;
    localparam int SCALE_W = 16;
    localparam int PTR_W   = 16;
    localparam int ORIENT_W = 2;

    // With the default 272x480 panel, rotated coordinates span -239..511.
    localparam int COORD_W = POS_W + 2;
    localparam int PROD_W  = COORD_W + SCALE_W + 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_LEFT_DOWN  = 3'd1,
        EV_LEFT_UP    = 3'd2,
        EV_RIGHT_DOWN = 3'd3,
        EV_RIGHT_UP   = 3'd4,
        EV_MOVE       = 3'd5
    } event_kind_t;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_UPRIGHT = 2'd0,
        ORIENT_NINETY  = 2'd1,
        ORIENT_FLIPPED = 2'd2,
        ORIENT_TWO_SEVENTY = 2'd3
    } orient_t;

    localparam logic [CFG_IDX_W-1:0] REG_TILT_TOLERANCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHORT_SIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_LONG_SIDE  = 2'd2;

    localparam logic [TOL_W-1:0]   TILT_TOLERANCE_RESET   = 15'd350;
    localparam logic [SCALE_W-1:0] SCALE_SHORT_SIDE_RESET = 16'd241;
    localparam logic [SCALE_W-1:0] SCALE_LONG_SIDE_RESET  = 16'd136;
    localparam logic [PTR_W-1:0]   PTR_MAX = 16'hFFFF;

endpackage

FILE: hdl/touch_gesture_to_pointer.sv
// Channel   Direction  Payload
// s_        in         one sensor poll (accelerometer, touch count, first touch)
// m_        out        one pointer result per poll
// cfg_      in         register writes, no read-back
//
// Three register stages: input register, gesture/orientation decode with the
// state update, then scale multiply and saturation into the output register.
// One poll is accepted per cycle unless the output stalls; it passes the input and stage 2 registers before m_tvalid.
// All stages advance together whenever the output register is empty or taken.
// Reset is synchronous, active low, and restores the register defaults.
`include "assert_macros.svh"

module touch_gesture_to_pointer
    import tgp_pkg::*;
#(
    parameter int PANEL_WIDTH  = 272,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // accel_x[15:0], accel_y[31:16], touch_count[34:32], touch_x[43:35], touch_y[52:44]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pointer_x[15:0], pointer_y[31:16], orientation[33:32], orientation_changed[34]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // event_kind[2:0]
    output logic [2:0]             m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SCALE_W-1:0]     cfg_wdata
);

    localparam logic signed [COORD_W-1:0] PW = COORD_W'(PANEL_WIDTH);
    localparam logic signed [COORD_W-1:0] PH = COORD_W'(PANEL_HEIGHT);

    logic advance;

    // Configuration registers.
    logic [TOL_W-1:0]   tilt_tolerance_reg;
    logic [SCALE_W-1:0] scale_short_reg;
    logic [SCALE_W-1:0] scale_long_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tilt_tolerance_reg <= TILT_TOLERANCE_RESET;
            scale_short_reg    <= SCALE_SHORT_SIDE_RESET;
            scale_long_reg     <= SCALE_LONG_SIDE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TILT_TOLERANCE:   tilt_tolerance_reg <= cfg_wdata[TOL_W-1:0];
                REG_SCALE_SHORT_SIDE: scale_short_reg    <= cfg_wdata;
                REG_SCALE_LONG_SIDE:  scale_long_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: input register.
    logic                      in_valid_reg;
    logic signed [ACCEL_W-1:0] ax_reg, ay_reg;
    logic [COUNT_W-1:0]        cnt_reg;
    logic [POS_W-1:0]          tx_reg, ty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ax_reg  <= s_tdata[15:0];
            ay_reg  <= s_tdata[31:16];
            cnt_reg <= s_tdata[34:32];
            tx_reg  <= s_tdata[43:35];
            ty_reg  <= s_tdata[52:44];
        end
    end

    // Persistent gesture and orientation state.
    logic [ORIENT_W-1:0] orient_reg, orient_next;
    logic [COUNT_W-1:0]  prior_cnt_reg;
    logic [POS_W-1:0]    prior_x_reg, prior_y_reg;
    logic right_enable_reg, right_enable_next;
    logic right_armed_reg, right_armed_next;
    logic right_held_reg, right_held_next;
    logic right_just_reg, right_just_next;

    // Stage 2 decode.
    logic signed [ACCEL_W+1:0] ax_e, ay_e, tol_e, abx, aby;
    event_kind_t               ev_next;
    logic [POS_W-1:0]          bx, by;
    logic signed [COORD_W-1:0] xi, yi, rx_next, ry_next;
    logic                      land_next;

    always_comb begin
        ax_e  = (ACCEL_W+2)'(ax_reg);
        ay_e  = (ACCEL_W+2)'(ay_reg);
        tol_e = $signed({3'b000, tilt_tolerance_reg});
        abx   = ax_e[ACCEL_W+1] ? -ax_e : ax_e;
        aby   = ay_e[ACCEL_W+1] ? -ay_e : ay_e;

        orient_next = orient_reg;
        if (aby < tol_e) begin
            if (ax_e < -tol_e) orient_next = ORIENT_TWO_SEVENTY;
            if (ax_e > tol_e)  orient_next = ORIENT_NINETY;
        end
        if (abx < tol_e) begin
            if (ay_e > tol_e)  orient_next = ORIENT_UPRIGHT;
            if (ay_e < -tol_e) orient_next = ORIENT_FLIPPED;
        end

        ev_next           = EV_NONE;
        bx                = tx_reg;
        by                = ty_reg;
        right_enable_next = right_enable_reg;
        right_armed_next  = right_armed_reg;
        right_held_next   = right_held_reg;
        right_just_next   = right_just_reg;

        if (cnt_reg == COUNT_W'(0)) begin
            // A release reports where the finger was on the previous poll.
            bx = prior_x_reg;
            by = prior_y_reg;
            if (prior_cnt_reg != COUNT_W'(0)) begin
                ev_next = right_held_reg ? EV_RIGHT_UP : EV_LEFT_UP;
                if (right_just_reg) begin
                    right_just_next = 1'b0;
                end else if (right_held_reg) begin
                    right_held_next  = 1'b0;
                    right_armed_next = 1'b0;
                end
            end
        end else if (cnt_reg == COUNT_W'(1)) begin
            if (prior_cnt_reg == COUNT_W'(0)) begin
                ev_next = right_armed_reg ? EV_RIGHT_DOWN : EV_LEFT_DOWN;
                if (right_armed_reg) right_held_next = 1'b1;
            end else begin
                ev_next = EV_MOVE;
            end
        end else if (cnt_reg == COUNT_W'(2) && prior_cnt_reg < COUNT_W'(2)
                     && !right_just_reg && right_enable_reg) begin
            right_armed_next = 1'b1;
        end else if (cnt_reg == COUNT_W'(3) && prior_cnt_reg < COUNT_W'(3)) begin
            right_enable_next = !right_enable_reg;
            if (!right_enable_reg) right_just_next = 1'b1;
        end

        xi = $signed({2'b00, bx});
        yi = $signed({2'b00, by});
        land_next = 1'b0;
        case (orient_next)
            ORIENT_NINETY: begin
                rx_next   = PH - yi;
                ry_next   = xi;
                land_next = 1'b1;
            end
            ORIENT_FLIPPED: begin
                rx_next = PW - xi;
                ry_next = PH - yi;
            end
            ORIENT_TWO_SEVENTY: begin
                rx_next   = yi;
                ry_next   = PW - xi;
                land_next = 1'b1;
            end
            default: begin
                rx_next = xi;
                ry_next = yi;
            end
        endcase
        // No event reports a zero position.
        if (ev_next == EV_NONE) begin
            rx_next = '0;
            ry_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg       <= ORIENT_UPRIGHT;
            prior_cnt_reg    <= '0;
            prior_x_reg      <= '0;
            prior_y_reg      <= '0;
            right_enable_reg <= 1'b1;
            right_armed_reg  <= 1'b0;
            right_held_reg   <= 1'b0;
            right_just_reg   <= 1'b0;
        end else if (advance && in_valid_reg) begin
            orient_reg       <= orient_next;
            prior_cnt_reg    <= cnt_reg;
            prior_x_reg      <= tx_reg;
            prior_y_reg      <= ty_reg;
            right_enable_reg <= right_enable_next;
            right_armed_reg  <= right_armed_next;
            right_held_reg   <= right_held_next;
            right_just_reg   <= right_just_next;
        end
    end

    // Stage 2 register.
    logic                      mid_valid_reg;
    event_kind_t               ev_mid_reg;
    logic signed [COORD_W-1:0] rx_mid_reg, ry_mid_reg;
    logic                      land_mid_reg;
    logic [ORIENT_W-1:0]       orient_mid_reg;
    logic                      chg_mid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (advance) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            ev_mid_reg     <= ev_next;
            rx_mid_reg     <= rx_next;
            ry_mid_reg     <= ry_next;
            land_mid_reg   <= land_next;
            orient_mid_reg <= orient_next;
            chg_mid_reg    <= (orient_next != orient_reg);
        end
    end

    // Stage 3: scale and saturate.
    logic signed [SCALE_W:0]  scale_x, scale_y;
    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic [PTR_W-1:0]         px_next, py_next;

    function automatic logic [PTR_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p[PROD_W-1]) begin
            r = '0;
        end else if (|p[PROD_W-2:PTR_W]) begin
            r = PTR_MAX;
        end else begin
            r = p[PTR_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        scale_x = $signed({1'b0, land_mid_reg ? scale_long_reg : scale_short_reg});
        scale_y = $signed({1'b0, land_mid_reg ? scale_short_reg : scale_long_reg});
        prod_x  = PROD_W'(rx_mid_reg) * PROD_W'(scale_x);
        prod_y  = PROD_W'(ry_mid_reg) * PROD_W'(scale_y);
        px_next = saturate(prod_x);
        py_next = saturate(prod_y);
    end

    logic                m_valid_reg;
    event_kind_t         m_event_reg;
    logic [PTR_W-1:0]    m_px_reg, m_py_reg;
    logic [ORIENT_W-1:0] m_orient_reg;
    logic                m_chg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_event_reg  <= ev_mid_reg;
            m_px_reg     <= px_next;
            m_py_reg     <= py_next;
            m_orient_reg <= orient_mid_reg;
            m_chg_reg    <= chg_mid_reg;
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_event_reg;
    assign m_tdata  = {5'b00000, m_chg_reg, m_orient_reg, m_py_reg, m_px_reg};

    `ASSERT_IMPLIES(a_no_event_zero_pos, aclk, aresetn, m_tvalid && m_tuser == EV_NONE, m_tdata[31:0] == 32'd0)
    `ASSERT_IMPLIES(a_held_needs_armed, aclk, aresetn, right_held_reg, right_armed_reg)
    `ASSERT_IMPLIES(a_stall_blocks_input, aclk, aresetn, m_tvalid && !m_tready, !s_tready)

endmodule

FILE: dv/touch_gesture_to_pointer_checker.sv
module touch_gesture_to_pointer_checker
    import tgp_pkg::*;
#(
    parameter int PANEL_WIDTH  = 272,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // accel_x[15:0], accel_y[31:16], touch_count[34:32], touch_x[43:35], touch_y[52:44]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // pointer_x[15:0], pointer_y[31:16], orientation[33:32], orientation_changed[34]
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    // event_kind[2:0]
    input  logic [2:0]             m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SCALE_W-1:0]     cfg_wdata,
    output int                     fail_count,
    output int                     pending_results
);

    typedef struct {
        event_kind_t        kind;
        logic [PTR_W-1:0]   x;
        logic [PTR_W-1:0]   y;
        orient_t            orient;
        logic               changed;
    } pointer_result_t;

    pointer_result_t expected_pointers[$];

    logic [TOL_W-1:0]   tol_reg;
    logic [SCALE_W-1:0] short_scale;
    logic [SCALE_W-1:0] long_scale;

    orient_t            orient;
    logic [COUNT_W-1:0] last_count;
    logic [POS_W-1:0]   last_x;
    logic [POS_W-1:0]   last_y;
    logic               rc_enable;
    logic               rc_armed;
    logic               rc_held;
    logic               rc_fresh;

    int mismatch_total = 0;
    int result_index = 0;

    assign fail_count = mismatch_total;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH result %0d: %s", $time, result_index, what);
        mismatch_total++;
    endtask

    function automatic logic [PTR_W-1:0] scale_saturate(input int coord,
                                                        input logic [SCALE_W-1:0] scale);
        longint product;
        product = longint'(coord) * longint'(scale);
        if (product < 0) return '0;
        if (product > 65535) return PTR_MAX;
        return product[PTR_W-1:0];
    endfunction

    // Rotate a panel position into the current orientation, then scale it.
    function automatic void place_pointer(input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] py,
                                          output logic [PTR_W-1:0] ox,
                                          output logic [PTR_W-1:0] oy);
        int ix;
        int iy;
        int rx;
        int ry;
        bit landscape;
        ix = int'(px);
        iy = int'(py);
        landscape = 1'b0;
        case (orient)
            ORIENT_NINETY: begin
                rx = PANEL_HEIGHT - iy;
                ry = ix;
                landscape = 1'b1;
            end
            ORIENT_FLIPPED: begin
                rx = PANEL_WIDTH - ix;
                ry = PANEL_HEIGHT - iy;
            end
            ORIENT_TWO_SEVENTY: begin
                rx = iy;
                ry = PANEL_WIDTH - ix;
                landscape = 1'b1;
            end
            default: begin
                rx = ix;
                ry = iy;
            end
        endcase
        ox = scale_saturate(rx, landscape ? long_scale : short_scale);
        oy = scale_saturate(ry, landscape ? short_scale : long_scale);
    endfunction

    task automatic predict_pointer(input logic [IN_TDATA_W-1:0] poll);
        int ax;
        int ay;
        int abx;
        int aby;
        int tol;
        logic [COUNT_W-1:0] cnt;
        logic [POS_W-1:0] tx;
        logic [POS_W-1:0] ty;
        orient_t prior_orient;
        pointer_result_t res;

        ax = int'($signed(poll[15:0]));
        ay = int'($signed(poll[31:16]));
        cnt = poll[34:32];
        tx = poll[43:35];
        ty = poll[52:44];
        tol = int'(tol_reg);
        abx = (ax < 0) ? -ax : ax;
        aby = (ay < 0) ? -ay : ay;
        prior_orient = orient;
        res.kind = EV_NONE;
        res.x = '0;
        res.y = '0;

        // The vertical axis test runs second, so it wins when both apply.
        if (aby < tol) begin
            if (ax < -tol) orient = ORIENT_TWO_SEVENTY;
            if (ax > tol) orient = ORIENT_NINETY;
        end
        if (abx < tol) begin
            if (ay > tol) orient = ORIENT_UPRIGHT;
            if (ay < -tol) orient = ORIENT_FLIPPED;
        end

        if (cnt == 0) begin
            if (last_count != 0) begin
                res.kind = rc_held ? EV_RIGHT_UP : EV_LEFT_UP;
                place_pointer(last_x, last_y, res.x, res.y);
                if (rc_fresh) begin
                    rc_fresh = 1'b0;
                end else if (rc_held) begin
                    rc_held = 1'b0;
                    rc_armed = 1'b0;
                end
            end
        end else if (cnt == 1) begin
            if (last_count == 0) begin
                res.kind = rc_armed ? EV_RIGHT_DOWN : EV_LEFT_DOWN;
                if (rc_armed) rc_held = 1'b1;
            end else begin
                res.kind = EV_MOVE;
            end
            place_pointer(tx, ty, res.x, res.y);
        end else if (cnt == 2 && last_count < 2 && !rc_fresh && rc_enable) begin
            rc_armed = 1'b1;
        end else if (cnt == 3 && last_count < 3) begin
            rc_enable = !rc_enable;
            if (rc_enable) rc_fresh = 1'b1;
        end

        last_count = cnt;
        last_x = tx;
        last_y = ty;
        res.orient = orient;
        res.changed = (orient != prior_orient);
        expected_pointers.push_back(res);
    endtask

    always @(posedge aclk) begin
        pointer_result_t want;
        if (!aresetn) begin
            tol_reg = TILT_TOLERANCE_RESET;
            short_scale = SCALE_SHORT_SIDE_RESET;
            long_scale = SCALE_LONG_SIDE_RESET;
            orient = ORIENT_UPRIGHT;
            last_count = '0;
            last_x = '0;
            last_y = '0;
            rc_enable = 1'b1;
            rc_armed = 1'b0;
            rc_held = 1'b0;
            rc_fresh = 1'b0;
            expected_pointers.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TILT_TOLERANCE:   tol_reg = cfg_wdata[TOL_W-1:0];
                    REG_SCALE_SHORT_SIDE: short_scale = cfg_wdata;
                    REG_SCALE_LONG_SIDE:  long_scale = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_pointer(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_pointers.size() == 0) begin
                    report_mismatch("result transaction with no poll outstanding");
                end else begin
                    want = expected_pointers.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("event_kind got %0d expected %0d",
                                                  m_tuser, want.kind));
                    if (m_tdata[15:0] !== want.x)
                        report_mismatch($sformatf("pointer_x got %0d expected %0d",
                                                  m_tdata[15:0], want.x));
                    if (m_tdata[31:16] !== want.y)
                        report_mismatch($sformatf("pointer_y got %0d expected %0d",
                                                  m_tdata[31:16], want.y));
                    if (m_tdata[33:32] !== want.orient)
                        report_mismatch($sformatf("orientation got %0d expected %0d",
                                                  m_tdata[33:32], want.orient));
                    if (m_tdata[34] !== want.changed)
                        report_mismatch($sformatf("orientation_changed got %0b expected %0b",
                                                  m_tdata[34], want.changed));
                end
                result_index++;
            end
        end
        pending_results = expected_pointers.size();
    end

endmodule

FILE: dv/touch_gesture_to_pointer_tb.sv
module touch_gesture_to_pointer_tb;
    import tgp_pkg::*;

    localparam int PANEL_W         = 272;
    localparam int PANEL_H         = 480;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PHASE_POLLS     = 140;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_TILT_TOLERANCE;
    logic [SCALE_W-1:0]     cfg_wdata = '0;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int stim_tol = int'(TILT_TOLERANCE_RESET);
    bit steady_flow = 1'b0;
    bit hold_off_req = 1'b0;

    touch_gesture_to_pointer #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    touch_gesture_to_pointer_checker #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int idle_length();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        bit hold_off_done;
        stall = 0;
        hold_off_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0) stall = idle_length();
            end
        end
    end

    function automatic int poll_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 9);
        if (r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Returns right after the rising edge at which the poll was taken.
    task automatic send_poll(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [2:0] cnt, input logic [8:0] tx,
                             input logic [8:0] ty);
        int gap;
        gap = poll_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, ty, tx, cnt, ay, ax};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic go_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_quiet();
        wait (pending_results == 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_settings(input logic [SCALE_W-1:0] tol,
                                    input logic [SCALE_W-1:0] short_side,
                                    input logic [SCALE_W-1:0] long_side);
        wait_drained();
        repeat (4) @(posedge aclk);
        write_reg(REG_TILT_TOLERANCE, tol);
        write_reg(REG_SCALE_SHORT_SIDE, short_side);
        write_reg(REG_SCALE_LONG_SIDE, long_side);
        stim_tol = int'(tol[TOL_W-1:0]);
    endtask

    function automatic logic [15:0] clamp_accel(input int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic int signed_within(input int limit);
        int v;
        v = $urandom_range(0, limit);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Half are readings that push toward one orientation, with the other axis inside
    // the tolerance window; the rest are noise, lie wholly inside the window, or sit on its edge.
    task automatic random_accel(output logic [15:0] ax, output logic [15:0] ay);
        int big;
        int boundary;
        case ($urandom_range(0, 9))
            0, 1: begin
                ax = 16'($urandom);
                ay = 16'($urandom);
            end
            2, 3: begin
                ax = clamp_accel(signed_within(stim_tol));
                ay = clamp_accel(signed_within(stim_tol));
            end
            9: begin
                boundary = stim_tol + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) boundary = -boundary;
                if ($urandom_range(0, 1)) begin
                    ax = clamp_accel(boundary);
                    ay = clamp_accel(signed_within(stim_tol));
                end else begin
                    ay = clamp_accel(boundary);
                    ax = clamp_accel(signed_within(stim_tol));
                end
            end
            default: begin
                big = stim_tol + $urandom_range(1, 3000);
                ax = clamp_accel(signed_within(stim_tol));
                ay = clamp_accel(signed_within(stim_tol));
                case ($urandom_range(0, 3))
                    0: ax = clamp_accel(big);
                    1: ax = clamp_accel(-big);
                    2: ay = clamp_accel(big);
                    default: ay = clamp_accel(-big);
                endcase
            end
        endcase
    endtask

    function automatic logic [8:0] touch_coord();
        if ($urandom_range(0, 7) != 0) return 9'($urandom_range(0, 511));
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd511;
            2: return 9'd272;
            3: return 9'd480;
            4: return 9'd271;
            default: return 9'd481;
        endcase
    endfunction

    task automatic random_poll(input logic [2:0] cnt, inout int polls);
        logic [15:0] ax;
        logic [15:0] ay;
        random_accel(ax, ay);
        send_poll(ax, ay, cnt, touch_coord(), touch_coord());
        polls++;
    endtask

    // One finger gesture sequence with random positions and tilt.
    task automatic play_gesture(inout int polls);
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 6);
                repeat (n) random_poll(3'd1, polls);
                repeat ($urandom_range(1, 2)) random_poll(3'd0, polls);
            end
            4, 5: begin
                repeat ($urandom_range(1, 2)) random_poll(3'd2, polls);
                random_poll(3'd0, polls);
                repeat ($urandom_range(1, 4)) random_poll(3'd1, polls);
                random_poll(3'd0, polls);
            end
            6: begin
                repeat ($urandom_range(1, 2)) random_poll(3'd3, polls);
                random_poll(3'd0, polls);
            end
            7: begin
                random_poll(3'd2, polls);
                random_poll(3'd3, polls);
                random_poll(3'd1, polls);
                random_poll(3'd0, polls);
            end
            default: begin
                repeat ($urandom_range(1, 4)) random_poll(3'($urandom_range(0, 7)), polls);
            end
        endcase
    endtask

    initial begin
        int polls;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed polls at the reset register values.
        send_poll(16'h0000, 16'h0000, 3'd1, 9'd0, 9'd0);
        send_poll(16'h7FFF, 16'h0000, 3'd1, 9'd511, 9'd511);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd100, 9'd200);
        send_poll(16'h8000, 16'h0000, 3'd2, 9'd300, 9'd400);
        send_poll(16'h0000, 16'h8000, 3'd0, 9'd5, 9'd6);
        send_poll(16'h0000, 16'h7FFF, 3'd1, 9'd272, 9'd480);
        send_poll(16'd350, 16'h0000, 3'd1, 9'd271, 9'd479);
        send_poll(16'd351, 16'd349, 3'd1, 9'd10, 9'd20);
        send_poll(-16'sd351, -16'sd350, 3'd0, 9'd33, 9'd44);
        send_poll(16'h0000, -16'sd351, 3'd3, 9'd1, 9'd2);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd3, 9'd4);
        send_poll(-16'sd351, 16'h0000, 3'd2, 9'd5, 9'd6);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd7, 9'd8);
        send_poll(16'h0000, 16'h0000, 3'd1, 9'd272, 9'd0);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd0, 9'd480);
        send_poll(16'h0000, 16'h0000, 3'd3, 9'd9, 9'd9);
        send_poll(16'h0000, 16'h0000, 3'd2, 9'd10, 9'd10);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd11, 9'd11);
        send_poll(16'h0000, 16'h0000, 3'd4, 9'd511, 9'd0);
        send_poll(16'h0000, 16'h0000, 3'd7, 9'd0, 9'd511);
        send_poll(16'h0000, 16'h0000, 3'd0, 9'd12, 9'd12);
        send_poll(16'h8000, 16'h8000, 3'd0, 9'd13, 9'd13);
        send_poll(16'h7FFF, 16'h7FFF, 3'd6, 9'd14, 9'd14);

        // Saturating scales, tolerance zero; the result side holds off early.
        program_settings(16'd0, 16'hFFFF, 16'hFFFF);
        hold_off_req = 1'b1;
        polls = 0;
        while (polls < PHASE_POLLS) play_gesture(polls);

        // Upper bits of the tolerance write are dropped by the register.
        program_settings(16'hFFFF, 16'd0, 16'd0);
        polls = 0;
        while (polls < PHASE_POLLS) play_gesture(polls);

        // Back-to-back transactions on both sides.
        program_settings(16'd1, 16'd1, 16'd1);
        steady_flow = 1'b1;
        polls = 0;
        while (polls < PHASE_POLLS) play_gesture(polls);
        steady_flow = 1'b0;

        program_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 400)),
                         16'($urandom_range(0, 400)));
        polls = 0;
        while (polls < PHASE_POLLS / 2) play_gesture(polls);
        wait_drained();
        while (polls < PHASE_POLLS) play_gesture(polls);

        program_settings(TILT_TOLERANCE_RESET, SCALE_SHORT_SIDE_RESET, SCALE_LONG_SIDE_RESET);
        polls = 0;
        while (polls < PHASE_POLLS) play_gesture(polls);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/tgp_pkg.sv
hdl/touch_gesture_to_pointer.sv
dv/touch_gesture_to_pointer_checker.sv
dv/touch_gesture_to_pointer_tb.sv
